// ===== sv/l3cs_pkg.sv =====
`default_nettype none

package l3cs_pkg;

  // Width of the input byte and default number of bits sent per transfer
  localparam int unsigned InByteW      = 8;
  localparam int unsigned ByteBitsDef  = 8;

  // Transfer kinds carried on the input tuser flag
  localparam logic CmdAddr = 1'b0;
  localparam logic CmdData = 1'b1;

  // One pin change as handed from the sequencer to the output register
  typedef struct packed {
    logic last;
    logic hold;
    logic data;
    logic clock;
    logic mode;
  } pins_t;

  // Sequencer phases, one-hot
  typedef enum logic [6:0] {
    ST_IDLE  = 7'b000_0001,
    ST_HEAD0 = 7'b000_0010,
    ST_HEAD1 = 7'b000_0100,
    ST_HEAD2 = 7'b000_1000,
    ST_BIT   = 7'b001_0000,
    ST_TAIL0 = 7'b010_0000,
    ST_TAIL1 = 7'b100_0000
  } seq_state_e;

  // Sub-steps of one bit: clock low, data set, clock high
  localparam logic [1:0] StepClkLo = 2'd0;
  localparam logic [1:0] StepData  = 2'd1;
  localparam logic [1:0] StepClkHi = 2'd2;

endpackage

`default_nettype wire

// ===== sv/l3cs_seq.sv =====
`default_nettype none

// Pin sequencer: walks the framing and bit steps of one transfer,
// presenting the current pin change and moving on when advance_i is high.
module l3cs_seq #(
  parameter int unsigned BYTE_BITS = l3cs_pkg::ByteBitsDef
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start_i,
  input  wire logic                            cmd_i,
  input  wire logic [l3cs_pkg::InByteW-1:0]    byte_i,
  input  wire logic                            advance_i,
  output l3cs_pkg::pins_t                      pins_o,
  output logic                                 busy_o,
  output logic                                 final_o
);

  localparam int unsigned BitW = (BYTE_BITS > 1) ? $clog2(BYTE_BITS) : 1;
  localparam logic [BitW-1:0] LastBit = BitW'(BYTE_BITS - 1);

  l3cs_pkg::seq_state_e state_q, state_d;
  logic                 kind_q, kind_d;
  logic [BYTE_BITS-1:0] shift_q, shift_d;
  logic [BitW-1:0]      bit_q, bit_d;
  logic [1:0]           step_q, step_d;
  logic                 dlev_q, dlev_d;

  // Byte zero-extended so that bits beyond the input byte go out as 0
  logic [BYTE_BITS+l3cs_pkg::InByteW-1:0] byte_ext;
  assign byte_ext = {{BYTE_BITS{1'b0}}, byte_i};

  assign busy_o  = (state_q != l3cs_pkg::ST_IDLE);
  assign final_o = (state_q == l3cs_pkg::ST_TAIL1);

  // Current pin change
  always_comb begin
    pins_o = '{last: 1'b0, hold: 1'b1, data: dlev_q, clock: 1'b1, mode: 1'b1};
    unique case (state_q)
      l3cs_pkg::ST_IDLE: begin
      end
      l3cs_pkg::ST_HEAD0: begin
        if (kind_q == l3cs_pkg::CmdAddr) begin
          pins_o.mode = 1'b0;
          pins_o.data = 1'b0;
        end
      end
      l3cs_pkg::ST_HEAD1: begin
        pins_o.mode = 1'b0;
      end
      l3cs_pkg::ST_HEAD2: begin
        pins_o.clock = 1'b0;
      end
      l3cs_pkg::ST_BIT: begin
        pins_o.mode = kind_q;
        unique case (step_q)
          l3cs_pkg::StepClkLo: pins_o.clock = 1'b0;
          l3cs_pkg::StepData: begin
            pins_o.clock = 1'b0;
            pins_o.data  = shift_q[0];
          end
          default: begin
          end
        endcase
      end
      l3cs_pkg::ST_TAIL0: begin
        pins_o.mode = 1'b0;
      end
      l3cs_pkg::ST_TAIL1: begin
        pins_o.last = 1'b1;
        pins_o.hold = (kind_q == l3cs_pkg::CmdAddr);
      end
      default: begin
      end
    endcase
  end

  // Next state
  always_comb begin
    state_d = state_q;
    kind_d  = kind_q;
    shift_d = shift_q;
    bit_d   = bit_q;
    step_d  = step_q;
    dlev_d  = dlev_q;
    if (advance_i) begin
      dlev_d = pins_o.data;
      unique case (state_q)
        l3cs_pkg::ST_HEAD0: begin
          if (kind_q == l3cs_pkg::CmdAddr) begin
            state_d = l3cs_pkg::ST_BIT;
            step_d  = l3cs_pkg::StepClkLo;
          end else begin
            state_d = l3cs_pkg::ST_HEAD1;
          end
        end
        l3cs_pkg::ST_HEAD1: state_d = l3cs_pkg::ST_HEAD2;
        l3cs_pkg::ST_HEAD2: begin
          // clock-low step of the first bit is merged into this change
          state_d = l3cs_pkg::ST_BIT;
          step_d  = l3cs_pkg::StepData;
        end
        l3cs_pkg::ST_BIT: begin
          if (step_q == l3cs_pkg::StepClkHi) begin
            step_d  = l3cs_pkg::StepClkLo;
            shift_d = shift_q >> 1;
            bit_d   = bit_q + 1'b1;
            if (bit_q == LastBit) begin
              state_d = (kind_q == l3cs_pkg::CmdAddr) ? l3cs_pkg::ST_TAIL1
                                                      : l3cs_pkg::ST_TAIL0;
            end
          end else begin
            step_d = step_q + 1'b1;
          end
        end
        l3cs_pkg::ST_TAIL0: state_d = l3cs_pkg::ST_TAIL1;
        l3cs_pkg::ST_TAIL1: state_d = l3cs_pkg::ST_IDLE;
        default: begin
        end
      endcase
    end
    // New transfer; may coincide with the final change of the previous one
    if (start_i) begin
      state_d = l3cs_pkg::ST_HEAD0;
      kind_d  = cmd_i;
      shift_d = byte_ext[BYTE_BITS-1:0];
      bit_d   = '0;
      step_d  = l3cs_pkg::StepClkLo;
    end
  end

  // Control and pin-level registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= l3cs_pkg::ST_IDLE;
      kind_q  <= l3cs_pkg::CmdAddr;
      bit_q   <= '0;
      step_q  <= l3cs_pkg::StepClkLo;
      dlev_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      kind_q  <= kind_d;
      bit_q   <= bit_d;
      step_q  <= step_d;
      dlev_q  <= dlev_d;
    end
  end

  // Shift register, payload only
  always_ff @(posedge clk_i) begin
    shift_q <= shift_d;
  end

endmodule

`default_nettype wire

// ===== sv/l3_codec_control_serializer.sv =====
// After a byte's word is accepted, its first pin change is registered by the sequencer
// state, then the output register. One pin change per cycle unless m_axis_tready_i is low;
// an address byte makes 2 + 3*BYTE_BITS changes and a data byte 4 + 3*BYTE_BITS.
// The next byte is accepted in the cycle its predecessor's final change is registered.
// Reset: sequencer idle, no output word pending, data line level 0 (mode and clock 1).
`default_nettype none

module l3_codec_control_serializer #(
  parameter int unsigned BYTE_BITS = l3cs_pkg::ByteBitsDef
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       s_axis_tvalid_i,
  output logic            s_axis_tready_o,
  input  wire logic [7:0] s_axis_tdata_i,   // [7:0] byte_value
  input  wire logic       s_axis_tuser_i,   // [0] cmd
  output logic            m_axis_tvalid_o,
  input  wire logic       m_axis_tready_i,
  output logic [7:0]      m_axis_tdata_o,   // [0] mode_pin [1] clock_pin [2] data_pin
                                            // [3] hold_after [7:4] zero
  output logic            m_axis_tlast_o    // last
);

  l3cs_pkg::pins_t pins;
  l3cs_pkg::pins_t out_q;
  logic            busy;
  logic            fin;
  logic            out_load;
  logic            accept;
  logic            mvalid_q, mvalid_d;

  // Output register takes a change when empty or being drained
  assign out_load        = busy && (!mvalid_q || m_axis_tready_i);
  assign s_axis_tready_o = !busy || (fin && out_load);
  assign accept          = s_axis_tvalid_i && s_axis_tready_o;

  l3cs_seq #(
    .BYTE_BITS(BYTE_BITS)
  ) u_seq (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (accept),
    .cmd_i     (s_axis_tuser_i),
    .byte_i    (s_axis_tdata_i),
    .advance_i (out_load),
    .pins_o    (pins),
    .busy_o    (busy),
    .final_o   (fin)
  );

  // Output word valid
  always_comb begin
    mvalid_d = mvalid_q;
    if (out_load) begin
      mvalid_d = 1'b1;
    end else if (m_axis_tready_i) begin
      mvalid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mvalid_q <= 1'b0;
    end else begin
      mvalid_q <= mvalid_d;
    end
  end

  // Output payload
  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_q <= pins;
    end
  end

  assign m_axis_tvalid_o = mvalid_q;
  assign m_axis_tdata_o  = {4'b0000, out_q.hold, out_q.data, out_q.clock, out_q.mode};
  assign m_axis_tlast_o  = out_q.last;

endmodule

`default_nettype wire
